/* rtl/core/psc_pkg.sv */
// psc_pkg: shared types and codes for the pileup snp caller
// no dependencies
`default_nettype none
package psc_pkg;

  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_CIGAR = 3'd2;
  localparam logic [2:0] KIND_BASE  = 3'd3;
  localparam logic [2:0] KIND_EVAL  = 3'd4;

  localparam logic [3:0] OP_M = 4'd0;
  localparam logic [3:0] OP_I = 4'd1;
  localparam logic [3:0] OP_D = 4'd2;
  localparam logic [3:0] OP_N = 4'd3;
  localparam logic [3:0] OP_S = 4'd4;

  localparam logic [2:0] BASE_N = 3'd4;

  localparam logic [1:0] CFG_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_MIN_DEP  = 2'd1;
  localparam logic [1:0] CFG_MIN_FRAC = 2'd2;
  localparam logic [1:0] CFG_MAX_DEP  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] site;
    logic [31:0] genome_pos;
    logic [2:0]  base_code;
    logic [3:0]  op_code;
    logic [15:0] op_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] site_out;
    logic [2:0]  ref_out;
    logic        is_snp;
    logic [3:0]  alt_mask;
    logic [17:0] depth;
    logic [15:0] count_a;
    logic [15:0] count_t;
    logic [15:0] count_g;
    logic [15:0] count_c;
  } out_item_t;

  // back-end commands
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_e;

endpackage
`default_nettype wire

/* rtl/core/psc_if.sv */
// psc_if: valid/ready stream interface carrying one payload
// depends on nothing; payload type is a parameter
`default_nettype none
interface psc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/psc_ram.sv */
// psc_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module psc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/psc_front.sv */
// psc_front: accepts items, tracks the read cursor and cigar state,
// turns items into back-end commands; depends on psc_pkg
`default_nettype none
module psc_front #(
  parameter int unsigned SegmentSites = 65536
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [31:0]                     segment_offset_i,
  input  wire logic                            in_valid_i,
  input  wire psc_pkg::in_item_t               in_data_i,
  output logic                                 in_ready_o,
  output logic                                 cmd_valid_o,
  output psc_pkg::cmd_e                        cmd_o,
  output logic [$clog2(SegmentSites)-1:0]      cmd_addr_o,
  output logic                                 cmd_oob_o,
  output logic [15:0]                          cmd_site_o,
  output logic [2:0]                           cmd_base_o,
  input  wire logic                            cmd_ready_i
);
  localparam int unsigned AW = $clog2(SegmentSites);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] SITES = CW'(SegmentSites);

  logic [CW-1:0] cursor_q, cursor_d;
  logic          rvalid_q, rvalid_d;
  logic [15:0]   match_q, match_d, skip_q, skip_d;
  logic          fire;
  logic [32:0]   diff;
  logic [CW+16:0] adv;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && cmd_ready_i;
  assign diff       = {1'b0, in_data_i.genome_pos} - {1'b0, segment_offset_i};
  assign adv        = (CW+17)'(cursor_q) + (CW+17)'(in_data_i.op_length);

  // classify the item and update read state
  always_comb begin
    cursor_d    = cursor_q;
    rvalid_d    = rvalid_q;
    match_d     = match_q;
    skip_d      = skip_q;
    cmd_valid_o = 1'b0;
    cmd_o       = psc_pkg::CMD_EVAL;
    cmd_addr_o  = cursor_q[AW-1:0];
    cmd_oob_o   = 1'b0;
    cmd_site_o  = in_data_i.site;
    cmd_base_o  = in_data_i.base_code;
    unique case (in_data_i.kind)
      psc_pkg::KIND_LOAD: begin
        cmd_o      = psc_pkg::CMD_LOAD;
        cmd_addr_o = AW'(in_data_i.site);
        cmd_valid_o = in_valid_i && (32'(in_data_i.site) < 32'(SegmentSites));
        if (in_data_i.base_code > psc_pkg::BASE_N) begin
          cmd_base_o = psc_pkg::BASE_N;
        end
      end
      psc_pkg::KIND_START: begin
        match_d = '0;
        skip_d  = '0;
        if (!diff[32] && diff[31:0] < 32'(SegmentSites)) begin
          cursor_d = CW'(diff[31:0]);
          rvalid_d = 1'b1;
        end else begin
          cursor_d = '0;
          rvalid_d = 1'b0;
        end
      end
      psc_pkg::KIND_CIGAR: begin
        if (rvalid_q) begin
          case (in_data_i.op_code)
            psc_pkg::OP_M: begin
              match_d = in_data_i.op_length;
              skip_d  = '0;
            end
            psc_pkg::OP_I: begin
              skip_d  = in_data_i.op_length;
              match_d = '0;
            end
            psc_pkg::OP_D, psc_pkg::OP_N, psc_pkg::OP_S: begin
              cursor_d = (adv > (CW+17)'(SegmentSites)) ? SITES : adv[CW-1:0];
              match_d  = '0;
              skip_d   = '0;
            end
            default: ;
          endcase
        end
      end
      psc_pkg::KIND_BASE: begin
        if (rvalid_q) begin
          if (match_q != '0) begin
            cmd_o       = psc_pkg::CMD_COUNT;
            cmd_valid_o = in_valid_i && (in_data_i.base_code < psc_pkg::BASE_N)
                          && (cursor_q < SITES);
            if (cursor_q < SITES) begin
              cursor_d = cursor_q + CW'(1);
            end
            match_d = match_q - 16'd1;
          end else if (skip_q != '0) begin
            skip_d = skip_q - 16'd1;
          end
        end
      end
      psc_pkg::KIND_EVAL: begin
        cmd_o       = psc_pkg::CMD_EVAL;
        cmd_addr_o  = AW'(in_data_i.site);
        cmd_oob_o   = !(32'(in_data_i.site) < 32'(SegmentSites));
        cmd_valid_o = in_valid_i;
      end
      default: ;
    endcase
  end

  // read state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      rvalid_q <= 1'b0;
      match_q  <= '0;
      skip_q   <= '0;
    end else if (fire) begin
      cursor_q <= cursor_d;
      rvalid_q <= rvalid_d;
      match_q  <= match_d;
      skip_q   <= skip_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/psc_back.sv */
// psc_back: command queue plus count/reference store and call logic
// depends on psc_pkg, psc_ram
`default_nettype none
module psc_back #(
  parameter int unsigned SegmentSites = 65536,
  parameter int unsigned CountBits    = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [17:0]                 min_depth_i,
  input  wire logic [8:0]                  min_fraction_q8_i,
  input  wire logic [17:0]                 max_depth_i,
  input  wire logic                        cmd_valid_i,
  input  wire psc_pkg::cmd_e               cmd_i,
  input  wire logic [$clog2(SegmentSites)-1:0] cmd_addr_i,
  input  wire logic                        cmd_oob_i,
  input  wire logic [15:0]                 cmd_site_i,
  input  wire logic [2:0]                  cmd_base_i,
  output logic                             cmd_ready_o,
  output logic                             out_valid_o,
  output psc_pkg::out_item_t               out_data_o,
  input  wire logic                        out_ready_i
);
  localparam int unsigned AW = $clog2(SegmentSites);
  localparam int unsigned CB = CountBits;
  localparam logic [CB-1:0] CMAX = '1;

  typedef struct packed {
    psc_pkg::cmd_e cmd;
    logic [AW-1:0] addr;
    logic          oob;
    logic [15:0]   site;
    logic [2:0]    base;
  } cmd_t;

  // two-entry command queue
  cmd_t        q_mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        q_push, q_pop;
  cmd_t        head;

  // pipeline: stage 1 holds command while the ram reads
  logic        s1_valid_q;
  cmd_t        s1_q;
  logic        busy;

  assign head        = q_mem_q[rp_q];
  assign cmd_ready_o = (cnt_q != 2'd2);
  assign q_push      = cmd_valid_i && cmd_ready_o;
  // one command at a time in the ram read-modify-write; stall on full output
  assign busy        = s1_valid_q || (out_valid_o && !out_ready_i);
  assign q_pop       = (cnt_q != 2'd0) && !busy;

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem_q[wp_q] <= '{cmd: cmd_i, addr: cmd_addr_i, oob: cmd_oob_i,
                         site: cmd_site_i, base: cmd_base_i};
    end
    if (q_pop) begin
      s1_q <= head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= 1'b0;
      rp_q       <= 1'b0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (q_push) wp_q <= ~wp_q;
      if (q_pop)  rp_q <= ~rp_q;
      cnt_q      <= cnt_q + 2'(q_push) - 2'(q_pop);
      s1_valid_q <= q_pop;
    end
  end

  // stores
  logic [4*CB-1:0] cnt_rd, cnt_wd;
  logic [2:0]      ref_rd;
  logic            cnt_we, ref_we;
  logic [CB-1:0]   c [4];

  assign ref_we = s1_valid_q && (s1_q.cmd == psc_pkg::CMD_LOAD);
  assign cnt_we = s1_valid_q && (s1_q.cmd != psc_pkg::CMD_EVAL);

  psc_ram #(.Width(3), .Depth(SegmentSites)) u_ref (
    .clk_i, .we_i(ref_we), .waddr_i(s1_q.addr), .wdata_i(s1_q.base),
    .raddr_i(head.addr), .rdata_o(ref_rd));

  psc_ram #(.Width(4*CB), .Depth(SegmentSites)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(s1_q.addr), .wdata_i(cnt_wd),
    .raddr_i(head.addr), .rdata_o(cnt_rd));

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      c[j] = cnt_rd[j*CB +: CB];
    end
    cnt_wd = cnt_rd;
    if (s1_q.cmd == psc_pkg::CMD_LOAD) begin
      cnt_wd = '0;
    end else if (c[s1_q.base[1:0]] != CMAX) begin
      cnt_wd[s1_q.base[1:0]*CB +: CB] = c[s1_q.base[1:0]] + CB'(1);
    end
  end

  // call test, wide enough for four full counts
  logic [33:0] ec [4];
  logic [33:0] dep, nonref, least;
  logic [2:0]  eref;
  logic [3:0]  mask;
  logic        pass;
  logic [42:0] lhs, rhs;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ec[j] = s1_q.oob ? 34'd0 : 34'(c[j]);
    end
    eref   = s1_q.oob ? psc_pkg::BASE_N : ref_rd;
    dep    = ec[0] + ec[1] + ec[2] + ec[3];
    nonref = dep - ec[eref[1:0]];
    lhs    = 43'({nonref, 8'd0});
    rhs    = 43'(min_fraction_q8_i) * 43'(dep);
    pass   = (eref < psc_pkg::BASE_N) && !(lhs < rhs) &&
             (dep >= 34'(min_depth_i)) && (dep <= 34'(max_depth_i));
    least  = '1;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) != eref[1:0] && ec[j] < least) least = ec[j];
    end
    mask = '0;
    for (int j = 0; j < 4; j++) begin
      if (pass && 2'(j) != eref[1:0] && ec[j] > least) mask[j] = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_valid_q && s1_q.cmd == psc_pkg::CMD_EVAL) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.cmd == psc_pkg::CMD_EVAL) begin
      out_data_o <= '{site_out: s1_q.site, ref_out: eref, is_snp: (mask != '0),
                      alt_mask: mask, depth: dep[17:0],
                      count_a: ec[0][15:0], count_t: ec[1][15:0],
                      count_g: ec[2][15:0], count_c: ec[3][15:0]};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/pileup_snp_caller_unit.sv */
// pileup_snp_caller_unit: top level of the pileup snp caller
// depends on psc_pkg, psc_if, psc_front, psc_back, psc_ram
`default_nettype none
// Items that only move the read cursor (read start, cigar ops, bases that
// are skipped or not counted) are accepted by the front end while the
// two-entry command queue has room. Loads, counted bases and evaluates are
// queued to the back end, which does one read-modify-write of the site store
// at a time (ram read, then write), so a counted base is not started before
// the one ahead of it is written. The back end also halts while a result
// waits on a stalled output. An evaluate result passes through the command
// queue, stage 1 and the result register before it is presented. The count
// store is not cleared at reset: each site must be loaded before it is
// evaluated, and the load clears any counts gathered there before it.
module pileup_snp_caller_unit #(
  parameter int unsigned SEGMENT_SITES = 65536,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  psc_if.sink                                    in_if,
  psc_if.source                                  out_if
);
  localparam int unsigned AW = $clog2(SEGMENT_SITES);

  logic [31:0] seg_off_q;
  logic [17:0] min_dep_q, max_dep_q;
  logic [8:0]  min_frac_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_off_q  <= '0;
      min_dep_q  <= 18'd5;
      min_frac_q <= 9'd128;
      max_dep_q  <= 18'h3FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psc_pkg::CFG_OFFSET:   seg_off_q  <= cfg_data_i;
        psc_pkg::CFG_MIN_DEP:  min_dep_q  <= cfg_data_i[17:0];
        psc_pkg::CFG_MIN_FRAC: min_frac_q <= cfg_data_i[8:0];
        psc_pkg::CFG_MAX_DEP:  max_dep_q  <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  logic          cmd_valid, cmd_ready, cmd_oob;
  psc_pkg::cmd_e cmd;
  logic [AW-1:0] cmd_addr;
  logic [15:0]   cmd_site;
  logic [2:0]    cmd_base;

  psc_front #(.SegmentSites(SEGMENT_SITES)) u_front (
    .clk_i, .rst_ni, .segment_offset_i(seg_off_q),
    .in_valid_i(in_if.valid), .in_data_i(in_if.data), .in_ready_o(in_if.ready),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_addr_o(cmd_addr),
    .cmd_oob_o(cmd_oob), .cmd_site_o(cmd_site), .cmd_base_o(cmd_base),
    .cmd_ready_i(cmd_ready));

  psc_back #(.SegmentSites(SEGMENT_SITES), .CountBits(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .min_depth_i(min_dep_q), .min_fraction_q8_i(min_frac_q),
    .max_depth_i(max_dep_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_addr_i(cmd_addr), .cmd_oob_i(cmd_oob), .cmd_site_i(cmd_site),
    .cmd_base_i(cmd_base), .cmd_ready_o(cmd_ready),
    .out_valid_o(out_if.valid), .out_data_o(out_if.data),
    .out_ready_i(out_if.ready));

  // a called snp always flags at least one alternate
  a_snp_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.data.is_snp == (out_if.data.alt_mask != 4'd0)))
    else $error("is_snp disagrees with alt_mask");

  // no alternate is flagged at an N reference
  a_ref_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.ref_out == psc_pkg::BASE_N)
      |-> (out_if.data.alt_mask == 4'd0))
    else $error("alternate flagged at N reference");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.data)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

/* tb/tb_psc_checker.sv */
// tb_psc_checker: predicts the pileup snp caller and checks its results
// depends on psc_pkg and psc_if; watches the config port and both channels
`timescale 1ns / 100ps
module tb_psc_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  psc_if                                      in_mon,
  psc_if                                      out_mon,
  output int                                  errors_o,
  output int                                  pending_o,
  output int                                  calls_o,
  output int                                  snps_o
);
  localparam longint unsigned SITES   = 65536;
  localparam int unsigned     CNT_MAX = 65535;

  // predicted site store and read state
  bit [2:0]    ref_mem [SITES];
  bit [15:0]   cnt_mem [SITES][4];
  longint      cursor;
  bit          read_ok;
  int unsigned match_cnt;
  int unsigned skip_cnt;

  // register shadows
  bit [31:0] seg_off;
  bit [17:0] min_dep;
  bit [8:0]  min_frac;
  bit [17:0] max_dep;

  psc_pkg::out_item_t calls_q[$];

  function automatic void move_cursor(longint by);
    cursor = cursor + by;
    if (cursor > SITES) cursor = SITES;
  endfunction

  // one input transaction of the pileup, queues a call on evaluate
  function automatic void pileup_step(psc_pkg::in_item_t it);
    psc_pkg::out_item_t r;
    longint      c[4];
    longint      dep;
    longint      nonref;
    longint      least;
    bit [2:0]    rb;
    bit [3:0]    mask;
    longint      p;
    case (it.kind)
      psc_pkg::KIND_LOAD: begin
        ref_mem[it.site] = (it.base_code > psc_pkg::BASE_N) ? psc_pkg::BASE_N
                                                            : it.base_code;
        for (int j = 0; j < 4; j++) cnt_mem[it.site][j] = '0;
      end
      psc_pkg::KIND_START: begin
        match_cnt = 0;
        skip_cnt  = 0;
        p = longint'(it.genome_pos);
        if (p >= longint'(seg_off) && p - longint'(seg_off) < SITES) begin
          cursor  = p - longint'(seg_off);
          read_ok = 1'b1;
        end else begin
          cursor  = 0;
          read_ok = 1'b0;
        end
      end
      psc_pkg::KIND_CIGAR: begin
        if (read_ok) begin
          if (it.op_code == psc_pkg::OP_M) begin
            match_cnt = 32'(it.op_length);
            skip_cnt  = 0;
          end else if (it.op_code == psc_pkg::OP_I) begin
            skip_cnt  = 32'(it.op_length);
            match_cnt = 0;
          end else if (it.op_code == psc_pkg::OP_D || it.op_code == psc_pkg::OP_N ||
                       it.op_code == psc_pkg::OP_S) begin
            move_cursor(longint'(it.op_length));
            match_cnt = 0;
            skip_cnt  = 0;
          end
        end
      end
      psc_pkg::KIND_BASE: begin
        if (read_ok) begin
          if (match_cnt != 0) begin
            if (it.base_code < psc_pkg::BASE_N && cursor < SITES) begin
              if (cnt_mem[cursor][it.base_code] < CNT_MAX)
                cnt_mem[cursor][it.base_code]++;
            end
            move_cursor(1);
            match_cnt--;
          end else if (skip_cnt != 0) begin
            skip_cnt--;
          end
        end
      end
      psc_pkg::KIND_EVAL: begin
        rb   = ref_mem[it.site];
        dep  = 0;
        mask = '0;
        for (int j = 0; j < 4; j++) begin
          c[j] = cnt_mem[it.site][j];
          dep  = dep + c[j];
        end
        if (rb < psc_pkg::BASE_N) begin
          nonref = dep - c[rb];
          if (!(nonref * 256 < longint'(min_frac) * dep) && dep >= longint'(min_dep)
              && dep <= longint'(max_dep)) begin
            least = 64'h7fff_ffff_ffff_ffff;
            for (int j = 0; j < 4; j++)
              if (j != rb && c[j] < least) least = c[j];
            for (int j = 0; j < 4; j++)
              if (j != rb && c[j] > least) mask[j] = 1'b1;
          end
        end
        r.site_out = it.site;
        r.ref_out  = rb;
        r.is_snp   = (mask != 0);
        r.alt_mask = mask;
        r.depth    = dep[17:0];
        r.count_a  = c[0][15:0];
        r.count_t  = c[1][15:0];
        r.count_g  = c[2][15:0];
        r.count_c  = c[3][15:0];
        calls_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors_o++;
    end
  endfunction

  // watch config writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    psc_pkg::out_item_t e;
    psc_pkg::out_item_t a;
    if (!rst_ni) begin
      seg_off   <= '0;
      min_dep   <= 18'd5;
      min_frac  <= 9'd128;
      max_dep   <= 18'h3ffff;
      cursor    = 0;
      read_ok   = 1'b0;
      match_cnt = 0;
      skip_cnt  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psc_pkg::CFG_OFFSET:   seg_off  <= cfg_data_i;
          psc_pkg::CFG_MIN_DEP:  min_dep  <= cfg_data_i[17:0];
          psc_pkg::CFG_MIN_FRAC: min_frac <= cfg_data_i[8:0];
          psc_pkg::CFG_MAX_DEP:  max_dep  <= cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        if (calls_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %p", $time, a);
          errors_o++;
        end else begin
          e = calls_q.pop_front();
          calls_o++;
          if (a.is_snp) snps_o++;
          check_field("site_out", e.site_out, a.site_out);
          check_field("ref_out", e.ref_out, a.ref_out);
          check_field("is_snp", e.is_snp, a.is_snp);
          check_field("alt_mask", e.alt_mask, a.alt_mask);
          check_field("depth", e.depth, a.depth);
          check_field("count_a", e.count_a, a.count_a);
          check_field("count_t", e.count_t, a.count_t);
          check_field("count_g", e.count_g, a.count_g);
          check_field("count_c", e.count_c, a.count_c);
        end
      end
      if (in_mon.valid && in_mon.ready) pileup_step(in_mon.data);
      pending_o <= calls_q.size();
    end
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
    calls_o   = 0;
    snps_o    = 0;
  end
endmodule

/* tb/tb_pileup_snp_caller_unit.sv */
// tb_pileup_snp_caller_unit: stimulus and verdict for pileup_snp_caller_unit
// depends on psc_pkg, psc_if, the block and tb_psc_checker
`timescale 1ns / 100ps
module tb_pileup_snp_caller_unit;
  localparam longint MAX_CYCLES = 200000;
  localparam int     LO_END     = 100;     // sites 0..99 are loaded
  localparam int     HI_START   = 65436;   // sites 65436..65535 are loaded

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  psc_if #(.payload_t(psc_pkg::in_item_t))  in_ch ();
  psc_if #(.payload_t(psc_pkg::out_item_t)) out_ch ();

  int errors;
  int pending;
  int calls;
  int snps;

  int     send_gap;    // percent of cycles the sender idles
  int     recv_stall;  // percent of cycles the receiver stalls
  int     n_sent;
  longint cycles;

  // generator view of the read cursor, keeps counts on loaded sites only
  bit [31:0] g_off;
  longint    g_cur;
  bit        g_ok;

  pileup_snp_caller_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  tb_psc_checker i_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .calls_o   (calls),
    .snps_o    (snps)
  );

  always #5 clk_i = ~clk_i;

  // receiver stalls
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic psc_pkg::in_item_t noise_item(bit [2:0] kind);
    psc_pkg::in_item_t it;
    logic [95:0]       raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(psc_pkg::in_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  // one transaction on the input channel, valid held until taken;
  // valid stays up after acceptance so items can follow back to back
  task automatic send(psc_pkg::in_item_t it);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_gap) begin
        in_ch.valid <= 1'b0;
        continue;
      end
      in_ch.valid <= 1'b1;
      in_ch.data  <= it;
      break;
    end
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic set_regs(bit [31:0] off, bit [17:0] mind, bit [8:0] frac, bit [17:0] maxd);
    drain();
    write_reg(psc_pkg::CFG_OFFSET, off);
    write_reg(psc_pkg::CFG_MIN_DEP, {14'h0, mind});
    write_reg(psc_pkg::CFG_MIN_FRAC, {23'h0, frac});
    write_reg(psc_pkg::CFG_MAX_DEP, {14'h0, maxd});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    g_off = off;
  endtask

  task automatic op_item(bit [3:0] op, bit [15:0] len);
    psc_pkg::in_item_t it;
    it = noise_item(psc_pkg::KIND_CIGAR);
    it.op_code   = op;
    it.op_length = len;
    send(it);
  endtask

  task automatic base_item(bit [2:0] b);
    psc_pkg::in_item_t it;
    it = noise_item(psc_pkg::KIND_BASE);
    it.base_code = b;
    send(it);
  endtask

  task automatic start_item(bit [31:0] pos);
    psc_pkg::in_item_t it;
    it = noise_item(psc_pkg::KIND_START);
    it.genome_pos = pos;
    send(it);
    g_ok  = (pos >= g_off) && (pos - g_off < 65536);
    g_cur = g_ok ? longint'(pos - g_off) : 0;
  endtask

  task automatic site_item(bit [2:0] kind, bit [15:0] s, bit [2:0] b);
    psc_pkg::in_item_t it;
    it = noise_item(kind);
    it.site      = s;
    it.base_code = b;
    send(it);
  endtask

  function automatic bit [15:0] loaded_site();
    return $urandom_range(1) ? 16'($urandom_range(LO_END - 1))
                             : 16'($urandom_range(65535, HI_START));
  endfunction

  function automatic bit [2:0] pick_base();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
  endfunction

  // cursor move that lands on a loaded site or past the store
  function automatic bit [15:0] safe_skip();
    if (g_cur >= HI_START) return 16'($urandom);
    if ($urandom_range(4) == 0) return 16'($urandom_range(65535, 32'(HI_START - g_cur)));
    return 16'($urandom_range(32'(LO_END - g_cur)));
  endfunction

  // well-formed read with random ops and bases
  task automatic gen_read();
    int        n_ops;
    int        len;
    int        k;
    bit [3:0]  op;
    bit [32:0] pos;
    pos = {1'b0, g_off} + 33'(loaded_site());
    start_item(pos[31:0]);
    n_ops = $urandom_range(4, 1);
    for (int i = 0; i < n_ops; i++) begin
      op = ($urandom_range(3) != 0) ? 4'($urandom_range(psc_pkg::OP_S)) : 4'($urandom);
      if (op == psc_pkg::OP_M) begin
        len = $urandom_range(12);
        if (g_cur < LO_END && g_cur + len > LO_END) len = int'(LO_END - g_cur);
        op_item(op, 16'(len));
        k = ($urandom_range(7) == 0) ? $urandom_range(len) : len;
        for (int b = 0; b < k; b++) base_item(pick_base());
        g_cur = g_cur + k;
        if (g_cur > 65536) g_cur = 65536;
      end else if (op == psc_pkg::OP_I) begin
        op_item(op, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
        repeat ($urandom_range(4)) base_item(pick_base());
      end else if (op == psc_pkg::OP_D || op == psc_pkg::OP_N || op == psc_pkg::OP_S) begin
        len = g_ok ? int'(safe_skip()) : int'($urandom_range(65535));
        op_item(op, 16'(len));
        g_cur = g_cur + len;
        if (g_cur > 65536) g_cur = 65536;
      end else begin
        op_item(op, 16'($urandom));
      end
      if (!g_ok) break;
    end
  endtask

  // dropped read followed by ops and bases that must be ignored
  task automatic gen_noise();
    bit [31:0] pos;
    do pos = $urandom;
    while (pos >= g_off && pos - g_off < 65536);
    start_item(pos);
    repeat ($urandom_range(5, 1)) begin
      if ($urandom_range(1)) op_item(4'($urandom), 16'($urandom));
      else base_item(3'($urandom));
    end
  endtask

  task automatic random_phase(int target);
    int stop_at;
    int r;
    stop_at = n_sent + target;
    while (n_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) gen_read();
      else if (r < 78) site_item(psc_pkg::KIND_EVAL, loaded_site(), 3'($urandom));
      else if (r < 86) site_item(psc_pkg::KIND_LOAD, loaded_site(), 3'($urandom));
      else if (r < 95) gen_noise();
      else send(noise_item(3'($urandom_range(7, 5))));
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    send_gap    = 0;
    recv_stall  = 0;
    n_sent      = 0;
    cycles      = 0;
    g_off       = '0;
    g_cur       = 0;
    g_ok        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // load the two site windows used by the run
    for (int s = 0; s < LO_END; s++)
      site_item(psc_pkg::KIND_LOAD, 16'(s), 3'($urandom));
    for (int s = HI_START; s < 65536; s++)
      site_item(psc_pkg::KIND_LOAD, 16'(s), 3'($urandom));

    // directed: each op, uncounted codes, dropped reads, ignored kinds
    site_item(psc_pkg::KIND_LOAD, 16'd7, 3'd7);
    site_item(psc_pkg::KIND_EVAL, 16'd7, 3'd0);
    site_item(psc_pkg::KIND_LOAD, 16'd10, 3'd1);
    start_item(32'd10);
    op_item(psc_pkg::OP_M, 16'd3);
    base_item(3'd0);
    base_item(psc_pkg::BASE_N);
    base_item(3'd3);
    op_item(psc_pkg::OP_I, 16'd1);
    base_item(3'd2);
    op_item(psc_pkg::OP_D, 16'd1);
    op_item(psc_pkg::OP_N, 16'd1);
    op_item(psc_pkg::OP_S, 16'd1);
    op_item(4'd5, 16'd9);
    op_item(4'd8, 16'd9);
    op_item(4'd15, 16'hffff);
    op_item(psc_pkg::OP_M, 16'd1);
    base_item(3'd2);
    site_item(psc_pkg::KIND_EVAL, 16'd10, 3'd0);
    site_item(psc_pkg::KIND_EVAL, 16'd11, 3'd0);
    site_item(psc_pkg::KIND_EVAL, 16'd16, 3'd0);
    start_item(32'hffff_ffff);
    base_item(3'd1);
    send(noise_item(3'd5));
    send(noise_item(3'd7));

    // random phases over idle modes and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(32'd0, 18'd5, 9'd128, 18'h3ffff);
        1: set_regs(32'h8000_0000, 18'd0, 9'd0, 18'h3ffff);
        2: set_regs(32'd12345, 18'd3, 9'd256, 18'd40);
        3: set_regs(32'hffff_ffff, 18'd262140, 9'd64, 18'd0);
        4: set_regs(32'hffff_0000, 18'd1, 9'd32, 18'd20);
        5: set_regs($urandom, 18'($urandom_range(6)), 9'($urandom_range(256)), 18'h3ffff);
        6: set_regs(32'h7fff_ffff, 18'd2, 9'd200, 18'd262143);
        default: set_regs(32'd0, 18'd4, 9'd1, 18'd100);
      endcase
      case (ph % 4)
        0: begin send_gap = 0;  recv_stall = 0;  end
        1: begin send_gap = 67; recv_stall = 0;  end
        2: begin send_gap = 0;  recv_stall = 67; end
        default: begin send_gap = 26; recv_stall = 26; end
      endcase
      random_phase(135);
    end

    drain();
    $display("sent %0d input transactions, checked %0d calls (%0d variant sites)",
             n_sent, calls, snps);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
